@@ rtl/core/rlpw_pkg.sv @@
package rlpw_pkg;

	localparam int MAX_DIM = 4096;
	localparam int COORD_W = 12;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] INT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_ROW = 2'd0,
		CFG_START_COL = 2'd1,
		CFG_END_ROW   = 2'd2,
		CFG_END_COL   = 2'd3
	} cfg_index_t;

	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_DELIVER = 1'b1
	} command_t;

	typedef logic [COORD_W-1:0] coord_t;

	// coordinates at or past the raster size pin to the last cell
	function automatic coord_t clamp_coord(input coord_t v);
		logic [17:0] wide;
		wide = 18'(v);
		if (wide >= 18'(MAX_DIM))
			return COORD_W'(MAX_DIM - 1);
		return v;
	endfunction

endpackage

@@ rtl/core/raster_line_profile_walker.sv @@
// channel  | direction | handshake             | payload
// cfg      | in        | cfg_we                | cfg_index, cfg_data
// in       | in        | in_valid / in_stall   | command, cell_value, cell_is_null
// out      | out       | out_valid / out_stall | read_row, read_col, read_valid,
//          |           |                       | max_value, min_value, point_count, walk_done
//
// one beat in, one beat out; a beat passes the input register, then the step
// logic into the output register; one beat per cycle while the output is not stalled.
// the walk state updates once per beat with one add, compare and min/max.
// reset clears the walk state, the endpoint registers and the valid flags of both beat stages.
// a stalled output holds its beat; input stalls only when both stages are full
// and the output is stalled.
module raster_line_profile_walker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rlpw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rlpw_pkg::COORD_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic signed [rlpw_pkg::VALUE_W-1:0] cell_value,
	input  logic                          cell_is_null,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rlpw_pkg::COORD_W-1:0]   read_row,
	output logic [rlpw_pkg::COORD_W-1:0]   read_col,
	output logic                          read_valid,
	output logic signed [rlpw_pkg::VALUE_W-1:0] max_value,
	output logic signed [rlpw_pkg::VALUE_W-1:0] min_value,
	output logic [rlpw_pkg::COUNT_W-1:0]   point_count,
	output logic                          walk_done
);
	import rlpw_pkg::*;

	// endpoint registers
	coord_t start_row_q, start_col_q, end_row_q, end_col_q;

	// input stage
	logic                      valid_s1;
	logic                      command_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic                      null_s1;

	// walk state
	coord_t                    major_pos_q, minor_pos_q, major_len_q, minor_len_q;
	logic [COUNT_W-1:0]        remainder_acc_q, steps_left_q, taken_count_q;
	logic                      axis_is_row_q, walk_active_q, major_down_q, minor_down_q;
	logic signed [VALUE_W-1:0] running_max_q, running_min_q;

	// output register
	logic                      out_valid_q;
	coord_t                    read_row_q, read_col_q;
	logic                      read_valid_q, walk_done_q;
	logic signed [VALUE_W-1:0] max_value_q, min_value_q;
	logic [COUNT_W-1:0]        point_count_q;

	logic advance, process;

	// next-state values
	coord_t                    major_pos_nx, minor_pos_nx, major_len_nx, minor_len_nx;
	logic [COUNT_W-1:0]        remainder_acc_nx, steps_left_nx, taken_count_nx;
	logic                      axis_is_row_nx, walk_active_nx, major_down_nx, minor_down_nx;
	logic signed [VALUE_W-1:0] running_max_nx, running_min_nx;
	logic                      done_nx;

	coord_t                    dr, dc;
	logic signed [VALUE_W-1:0] v;
	logic [COUNT_W-1:0]        acc_sum;

	assign advance  = !out_valid_q || !out_stall;
	assign process  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q <= '0;
			start_col_q <= '0;
			end_row_q   <= '0;
			end_col_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_START_ROW: start_row_q <= clamp_coord(cfg_data);
				CFG_START_COL: start_col_q <= clamp_coord(cfg_data);
				CFG_END_ROW:   end_row_q   <= clamp_coord(cfg_data);
				CFG_END_COL:   end_col_q   <= clamp_coord(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			value_s1   <= cell_value;
			null_s1    <= cell_is_null;
		end
	end

	always_comb begin
		dr = (end_row_q >= start_row_q) ? end_row_q - start_row_q : start_row_q - end_row_q;
		dc = (end_col_q >= start_col_q) ? end_col_q - start_col_q : start_col_q - end_col_q;
		// a null cell, like a real most-negative value, never lowers the minimum
		v = null_s1 ? INT_MIN : value_s1;
		acc_sum = remainder_acc_q + COUNT_W'(minor_len_q);

		major_pos_nx     = major_pos_q;
		minor_pos_nx     = minor_pos_q;
		major_len_nx     = major_len_q;
		minor_len_nx     = minor_len_q;
		remainder_acc_nx = remainder_acc_q;
		steps_left_nx    = steps_left_q;
		taken_count_nx   = taken_count_q;
		axis_is_row_nx   = axis_is_row_q;
		walk_active_nx   = walk_active_q;
		major_down_nx    = major_down_q;
		minor_down_nx    = minor_down_q;
		running_max_nx   = running_max_q;
		running_min_nx   = running_min_q;
		done_nx          = 1'b0;

		if (command_t'(command_s1) == CMD_START) begin
			axis_is_row_nx = dr > dc;
			if (dr > dc) begin
				major_pos_nx  = start_row_q;
				minor_pos_nx  = start_col_q;
				major_len_nx  = dr;
				minor_len_nx  = dc;
				major_down_nx = end_row_q < start_row_q;
				minor_down_nx = end_col_q < start_col_q;
			end else begin
				major_pos_nx  = start_col_q;
				minor_pos_nx  = start_row_q;
				major_len_nx  = dc;
				minor_len_nx  = dr;
				major_down_nx = end_col_q < start_col_q;
				minor_down_nx = end_row_q < start_row_q;
			end
			// stepping toward lower minor takes the ceiling, so bias the accumulator
			remainder_acc_nx = (minor_down_nx && major_len_nx != '0)
				? COUNT_W'(major_len_nx) - COUNT_W'(1) : '0;
			steps_left_nx  = COUNT_W'(major_len_nx) + COUNT_W'(1);
			running_max_nx = '0;
			running_min_nx = '0;
			taken_count_nx = '0;
			walk_active_nx = 1'b1;
		end else if (walk_active_q) begin
			if (taken_count_q == '0) begin
				running_max_nx = v;
				running_min_nx = (v == INT_MIN) ? INT_MAX : v;
			end else begin
				if (v > running_max_q)
					running_max_nx = v;
				if (v < running_min_q && v != INT_MIN)
					running_min_nx = v;
			end
			taken_count_nx = taken_count_q + COUNT_W'(1);
			steps_left_nx  = steps_left_q - COUNT_W'(1);
			if (steps_left_q == COUNT_W'(1)) begin
				walk_active_nx = 1'b0;
				done_nx        = 1'b1;
			end else begin
				major_pos_nx     = major_down_q ? major_pos_q - COORD_W'(1)
					: major_pos_q + COORD_W'(1);
				remainder_acc_nx = acc_sum;
				if (major_len_q != '0 && acc_sum >= COUNT_W'(major_len_q)) begin
					remainder_acc_nx = acc_sum - COUNT_W'(major_len_q);
					minor_pos_nx     = minor_down_q ? minor_pos_q - COORD_W'(1)
						: minor_pos_q + COORD_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q     <= '0;
			minor_pos_q     <= '0;
			major_len_q     <= '0;
			minor_len_q     <= '0;
			remainder_acc_q <= '0;
			steps_left_q    <= '0;
			taken_count_q   <= '0;
			axis_is_row_q   <= 1'b0;
			walk_active_q   <= 1'b0;
			major_down_q    <= 1'b0;
			minor_down_q    <= 1'b0;
			running_max_q   <= '0;
			running_min_q   <= '0;
		end else if (process) begin
			major_pos_q     <= major_pos_nx;
			minor_pos_q     <= minor_pos_nx;
			major_len_q     <= major_len_nx;
			minor_len_q     <= minor_len_nx;
			remainder_acc_q <= remainder_acc_nx;
			steps_left_q    <= steps_left_nx;
			taken_count_q   <= taken_count_nx;
			axis_is_row_q   <= axis_is_row_nx;
			walk_active_q   <= walk_active_nx;
			major_down_q    <= major_down_nx;
			minor_down_q    <= minor_down_nx;
			running_max_q   <= running_max_nx;
			running_min_q   <= running_min_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			read_row_q    <= !walk_active_nx ? '0 : (axis_is_row_nx ? major_pos_nx : minor_pos_nx);
			read_col_q    <= !walk_active_nx ? '0 : (axis_is_row_nx ? minor_pos_nx : major_pos_nx);
			read_valid_q  <= walk_active_nx;
			max_value_q   <= running_max_nx;
			min_value_q   <= running_min_nx;
			point_count_q <= taken_count_nx;
			walk_done_q   <= done_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_row    = read_row_q;
	assign read_col    = read_col_q;
	assign read_valid  = read_valid_q;
	assign max_value   = max_value_q;
	assign min_value   = min_value_q;
	assign point_count = point_count_q;
	assign walk_done   = walk_done_q;

endmodule

@@ tb/tb_raster_line_profile_walker.sv @@
`timescale 1ns / 1ps

module tb_raster_line_profile_walker;
	import rlpw_pkg::*;

	typedef struct {
		coord_t                     row;
		coord_t                     col;
		logic                       more;
		logic signed [VALUE_W-1:0]  hi;
		logic signed [VALUE_W-1:0]  lo;
		logic [COUNT_W-1:0]         count;
		logic                       done;
	} profile_t;

	class profile_scoreboard;
		coord_t                    end_pts [4];
		int                        major_pos, minor_pos, rem_acc, steps_left;
		int                        major_len, minor_len, taken;
		bit                        row_major, walking, major_dec, minor_dec;
		logic signed [VALUE_W-1:0] peak_hi, peak_lo;
		profile_t                  pending_profiles [$];
		int                        errors;
		int                        beats_checked;

		function void write_reg(cfg_index_t idx, coord_t v);
			case (idx)
				CFG_START_ROW: end_pts[0] = v;
				CFG_START_COL: end_pts[1] = v;
				CFG_END_ROW:   end_pts[2] = v;
				CFG_END_COL:   end_pts[3] = v;
			endcase
		endfunction

		function void take_beat(command_t cmd, logic signed [VALUE_W-1:0] val, logic nul);
			profile_t                  p;
			logic signed [VALUE_W-1:0] v;
			int                        sr, sc, er, ec, dr, dc;
			bit                        done;
			done = 0;
			if (cmd == CMD_START) begin
				sr = end_pts[0];
				sc = end_pts[1];
				er = end_pts[2];
				ec = end_pts[3];
				dr = (er >= sr) ? er - sr : sr - er;
				dc = (ec >= sc) ? ec - sc : sc - ec;
				row_major = dr > dc;
				if (row_major) begin
					major_pos = sr; minor_pos = sc;
					major_len = dr; minor_len = dc;
					major_dec = er < sr; minor_dec = ec < sc;
				end else begin
					major_pos = sc; minor_pos = sr;
					major_len = dc; minor_len = dr;
					major_dec = ec < sc; minor_dec = er < sr;
				end
				// a falling minor axis rounds the offset up
				rem_acc = (minor_dec && major_len > 0) ? major_len - 1 : 0;
				steps_left = major_len + 1;
				peak_hi = '0;
				peak_lo = '0;
				taken = 0;
				walking = 1;
			end else if (walking) begin
				v = nul ? INT_MIN : val;
				if (taken == 0) begin
					peak_hi = v;
					peak_lo = (v == INT_MIN) ? INT_MAX : v;
				end else begin
					if (v > peak_hi) peak_hi = v;
					if (v < peak_lo && v != INT_MIN) peak_lo = v;
				end
				taken++;
				steps_left--;
				if (steps_left == 0) begin
					walking = 0;
					done = 1;
				end else begin
					major_pos = major_dec ? major_pos - 1 : major_pos + 1;
					rem_acc += minor_len;
					if (major_len > 0 && rem_acc >= major_len) begin
						rem_acc -= major_len;
						minor_pos = minor_dec ? minor_pos - 1 : minor_pos + 1;
					end
				end
			end
			p.row = '0;
			p.col = '0;
			if (walking) begin
				p.row = row_major ? coord_t'(major_pos) : coord_t'(minor_pos);
				p.col = row_major ? coord_t'(minor_pos) : coord_t'(major_pos);
			end
			p.more = walking;
			p.hi = peak_hi;
			p.lo = peak_lo;
			p.count = COUNT_W'(taken);
			p.done = done;
			pending_profiles.push_back(p);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				errors++;
				$display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void match_beat(profile_t got);
			profile_t want;
			beats_checked++;
			if (pending_profiles.size() == 0) begin
				errors++;
				$display("%0t unexpected beat: row %0d col %0d count %0d",
					$time, got.row, got.col, got.count);
				return;
			end
			want = pending_profiles.pop_front();
			compare_field("read_row", want.row, got.row);
			compare_field("read_col", want.col, got.col);
			compare_field("read_valid", want.more, got.more);
			compare_field("max_value", want.hi, got.hi);
			compare_field("min_value", want.lo, got.lo);
			compare_field("point_count", want.count, got.count);
			compare_field("walk_done", want.done, got.done);
		endfunction

		function int pending();
			return pending_profiles.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [COORD_W-1:0]         cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic                       command;
	logic signed [VALUE_W-1:0]  cell_value;
	logic                       cell_is_null;
	logic                       out_valid;
	logic                       out_stall;
	logic [COORD_W-1:0]         read_row;
	logic [COORD_W-1:0]         read_col;
	logic                       read_valid;
	logic signed [VALUE_W-1:0]  max_value;
	logic signed [VALUE_W-1:0]  min_value;
	logic [COUNT_W-1:0]         point_count;
	logic                       walk_done;

	profile_scoreboard sb = new();
	bit feed_burst;
	bit drain_burst;
	bit long_hold_done;

	raster_line_profile_walker uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.cell_value(cell_value),
		.cell_is_null(cell_is_null),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_row(read_row),
		.read_col(read_col),
		.read_valid(read_valid),
		.max_value(max_value),
		.min_value(min_value),
		.point_count(point_count),
		.walk_done(walk_done)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_raster_line_profile_walker failed");
		$finish;
	end

	task automatic send_item(command_t cmd, logic signed [VALUE_W-1:0] val, logic nul);
		int gap;
		if ($urandom_range(0, 39) == 0) feed_burst = !feed_burst;
		gap = feed_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		cell_value <= val;
		cell_is_null <= nul;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.take_beat(cmd, val, nul);
	endtask

	function automatic logic signed [VALUE_W-1:0] random_cell();
		case ($urandom_range(0, 9))
			0: return INT_MIN;
			1: return INT_MAX;
			2: return -INT_MAX;
			3, 4, 5: return 32'($urandom_range(0, 200)) - 32'd100;
			default: return $urandom;
		endcase
	endfunction

	task automatic deliver_random();
		send_item(CMD_DELIVER, random_cell(), $urandom_range(0, 5) == 0);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic set_endpoints(int sr, int sc, int er, int ec, output int span);
		cfg_index_t regs [4];
		coord_t     vals [4];
		int         dr, dc;
		regs = '{CFG_START_ROW, CFG_START_COL, CFG_END_ROW, CFG_END_COL};
		vals = '{coord_t'(sr), coord_t'(sc), coord_t'(er), coord_t'(ec)};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
		dr = (er >= sr) ? er - sr : sr - er;
		dc = (ec >= sc) ? ec - sc : sc - ec;
		span = (dr > dc) ? dr : dc;
	endtask

	function automatic int near_coord(int base);
		int v;
		v = base + int'($urandom_range(0, 32)) - 16;
		if (v < 0) v = 0;
		if (v > MAX_DIM - 1) v = MAX_DIM - 1;
		return v;
	endfunction

	// output side
	initial begin
		int n;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0) drain_burst = !drain_burst;
			n = drain_burst ? 0 : $urandom_range(0, 8);
			// one long hold-off so the pipe fills and the input stalls
			if (!long_hold_done && sb.beats_checked >= 200) begin
				n = 120;
				long_hold_done = 1;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		profile_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.row = read_row;
			got.col = read_col;
			got.more = read_valid;
			got.hi = max_value;
			got.lo = min_value;
			got.count = point_count;
			got.done = walk_done;
			sb.match_beat(got);
		end
	end

	initial begin
		int span, cells, counted, sr, sc, er, ec;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_START_ROW;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= CMD_DELIVER;
		cell_value <= '0;
		cell_is_null <= 1'b0;
		out_stall <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// delivery with no walk running, then a one-cell line
		send_item(CMD_DELIVER, 32'sd5, 1'b0);
		send_item(CMD_START, 32'sd0, 1'b0);
		send_item(CMD_DELIVER, -32'sd7, 1'b0);
		send_item(CMD_DELIVER, 32'sd9, 1'b1);

		// row-major, both axes falling; nulls and value extremes
		wait_idle();
		set_endpoints(MAX_DIM - 1, 3, MAX_DIM - 6, 0, span);
		send_item(CMD_START, INT_MAX, 1'b1);
		send_item(CMD_DELIVER, 32'sd3, 1'b1);
		send_item(CMD_DELIVER, INT_MAX, 1'b0);
		send_item(CMD_DELIVER, INT_MIN, 1'b0);
		send_item(CMD_DELIVER, -INT_MAX, 1'b0);
		send_item(CMD_DELIVER, -32'sd1, 1'b1);
		send_item(CMD_DELIVER, 32'sd0, 1'b0);

		// equal spans step by columns; column falls, row rises
		wait_idle();
		set_endpoints(0, MAX_DIM - 1, 3, MAX_DIM - 4, span);
		send_item(CMD_START, 32'sd0, 1'b0);
		send_item(CMD_DELIVER, INT_MIN, 1'b0);
		send_item(CMD_DELIVER, 32'sd44, 1'b0);
		send_item(CMD_START, 32'sd0, 1'b0);
		send_item(CMD_DELIVER, -32'sd12, 1'b0);
		send_item(CMD_DELIVER, -32'sd15, 1'b0);
		send_item(CMD_DELIVER, 32'sd100, 1'b0);
		send_item(CMD_DELIVER, 32'sd2, 1'b1);

		counted = 0;
		while (counted < 1100) begin
			wait_idle();
			if ($urandom_range(0, 7) == 0) begin
				sr = $urandom_range(0, 1) ? MAX_DIM - 1 : 0;
				sc = $urandom_range(0, 1) ? MAX_DIM - 1 : 0;
				er = $urandom_range(0, 1) ? MAX_DIM - 1 : 0;
				ec = $urandom_range(0, 1) ? MAX_DIM - 1 : 0;
			end else begin
				sr = $urandom_range(0, MAX_DIM - 1);
				sc = $urandom_range(0, MAX_DIM - 1);
				er = near_coord(sr);
				ec = near_coord(sc);
			end
			set_endpoints(sr, sc, er, ec, span);
			repeat ($urandom_range(1, 3)) begin
				send_item(command_t'(CMD_START), random_cell(), 1'($urandom_range(0, 1)));
				counted++;
				cells = span + 1;
				// long lines are cut short by the next start
				if (cells > 40)
					cells = $urandom_range(5, 40);
				else if ($urandom_range(0, 9) == 0)
					cells = $urandom_range(0, cells - 1);
				repeat (cells) deliver_random();
				counted += cells;
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 3)) deliver_random();
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_raster_line_profile_walker passed");
		else
			$display("tb_raster_line_profile_walker failed");
		$finish;
	end

endmodule
